// ===== rtl/core/wirms_pkg.sv =====
// Shared types and constants for the windowed integer RMS block.
package wirms_pkg;

  // Sample width in use and the widths that follow from it
  localparam int SAMPLE_BITS = 16;
  localparam int IN_BITS     = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam int LEN_BITS    = 8;
  localparam int SUM_BITS    = 2 * SAMPLE_BITS + LEN_BITS;
  localparam int SQ_BITS     = 2 * IN_BITS;
  localparam int ROOT_BITS   = SUM_BITS / 2;
  localparam int OUT_BITS    = 16;
  localparam int DIV_STEPS   = SUM_BITS;
  localparam int ROOT_STEPS  = ROOT_BITS;
  localparam int STEP_BITS   = $clog2(DIV_STEPS);

  localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(16);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accum;
    logic div_step;
    logic root_load;
    logic root_step;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic close;
    logic out_full;
  } dp_status_t;

endpackage

// ===== rtl/core/wirms_dp.sv =====
// Datapath: square-and-accumulate, serial divider, serial square root, output register.
module wirms_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [wirms_pkg::LEN_BITS-1:0]       cfg_wdata,
  input  logic [15:0]                          sample,
  input  wirms_pkg::dp_cmd_t                   cmd,
  output wirms_pkg::dp_status_t                status,
  input  logic                                 out_tready,
  output logic                                 out_tvalid,
  output logic [wirms_pkg::OUT_BITS-1:0]       out_data
);

  localparam int IN_BITS   = wirms_pkg::IN_BITS;
  localparam int SQ_BITS   = wirms_pkg::SQ_BITS;
  localparam int SUM_BITS  = wirms_pkg::SUM_BITS;
  localparam int LEN_BITS  = wirms_pkg::LEN_BITS;
  localparam int ROOT_BITS = wirms_pkg::ROOT_BITS;
  localparam int REM_W     = ROOT_BITS + 2;
  localparam int TRY_W     = ROOT_BITS + 4;

  logic [LEN_BITS-1:0] window_length;
  logic [SUM_BITS-1:0] square_sum;
  logic [LEN_BITS-1:0] sample_count;

  logic [LEN_BITS-1:0] len_eff;
  logic [IN_BITS-1:0]  s;
  logic [SQ_BITS-1:0]  sq;
  logic [SUM_BITS-1:0] sum_next;
  logic [LEN_BITS-1:0] count_next;

  // divider state: quotient shifts in where the dividend shifts out
  logic [SUM_BITS-1:0] quo;
  logic [LEN_BITS-1:0] div_rem;
  logic [LEN_BITS-1:0] divisor;
  logic [LEN_BITS:0]   div_try;
  logic                div_bit;

  // root state; the mean can use the full sum width when the length is lowered
  logic [SUM_BITS-1:0]  rad;
  logic [REM_W-1:0]     root_rem;
  logic [ROOT_BITS-1:0] root;
  logic [TRY_W-1:0]     root_try;
  logic [TRY_W-1:0]     root_trial;
  logic                 root_bit;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= wirms_pkg::LEN_RESET;
    end else if (cfg_we) begin
      window_length <= cfg_wdata;
    end
  end

  // Square and accumulate; a zero length counts as one
  assign len_eff    = (window_length == '0) ? LEN_BITS'(1) : window_length;
  assign s          = sample[IN_BITS-1:0];
  assign sq         = s * s;
  assign sum_next   = square_sum + SUM_BITS'(sq);
  assign count_next = sample_count + LEN_BITS'(1);
  assign status.close = (count_next >= len_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum   <= '0;
      sample_count <= '0;
    end else if (cmd.accum) begin
      if (status.close) begin
        square_sum   <= '0;
        sample_count <= '0;
      end else begin
        square_sum   <= sum_next;
        sample_count <= count_next;
      end
    end
  end

  // Restoring divide, one quotient bit a cycle
  assign div_try = {div_rem, quo[SUM_BITS-1]};
  assign div_bit = (div_try >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (cmd.accum && status.close) begin
      quo     <= sum_next;
      div_rem <= '0;
      divisor <= len_eff;
    end else if (cmd.div_step) begin
      quo <= {quo[SUM_BITS-2:0], div_bit};
      if (div_bit) begin
        div_rem <= LEN_BITS'(div_try - {1'b0, divisor});
      end else begin
        div_rem <= div_try[LEN_BITS-1:0];
      end
    end
  end

  // Digit-by-digit square root, one root bit a cycle
  assign root_try   = {root_rem, rad[SUM_BITS-1 -: 2]};
  assign root_trial = {2'b00, root, 2'b01};
  assign root_bit   = (root_try >= root_trial);

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      rad      <= quo;
      root_rem <= '0;
      root     <= '0;
    end else if (cmd.root_step) begin
      rad  <= {rad[SUM_BITS-3:0], 2'b00};
      root <= {root[ROOT_BITS-2:0], root_bit};
      if (root_bit) begin
        root_rem <= REM_W'(root_try - root_trial);
      end else begin
        root_rem <= root_try[REM_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  // low bits of the root only
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= wirms_pkg::OUT_BITS'(root);
    end
  end

  assign status.out_full = out_tvalid;

endmodule

// ===== rtl/core/wirms_ctrl.sv =====
// Controller: sequences accumulate, divide, root and result hand-off.
module wirms_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  out_tready,
  input  wirms_pkg::dp_status_t status,
  output wirms_pkg::dp_cmd_t    cmd
);

  localparam int STEP_BITS = wirms_pkg::STEP_BITS;

  wirms_pkg::state_t state, state_next;
  logic [STEP_BITS-1:0] step, step_next;
  logic accept;

  assign in_tready = (state == wirms_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wirms_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      wirms_pkg::ST_IDLE: begin
        if (accept && status.close) begin
          state_next = wirms_pkg::ST_DIV;
          step_next  = STEP_BITS'(wirms_pkg::DIV_STEPS - 1);
        end
      end
      wirms_pkg::ST_DIV: begin
        step_next = step - STEP_BITS'(1);
        if (step == '0) begin
          state_next = wirms_pkg::ST_ROOT_INIT;
        end
      end
      wirms_pkg::ST_ROOT_INIT: begin
        state_next = wirms_pkg::ST_ROOT;
        step_next  = STEP_BITS'(wirms_pkg::ROOT_STEPS - 1);
      end
      wirms_pkg::ST_ROOT: begin
        step_next = step - STEP_BITS'(1);
        if (step == '0) begin
          state_next = wirms_pkg::ST_FINISH;
        end
      end
      wirms_pkg::ST_FINISH: begin
        if (!status.out_full || out_tready) begin
          state_next = wirms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wirms_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state)
      wirms_pkg::ST_IDLE:      cmd.accum     = accept;
      wirms_pkg::ST_DIV:       cmd.div_step  = 1'b1;
      wirms_pkg::ST_ROOT_INIT: cmd.root_load = 1'b1;
      wirms_pkg::ST_ROOT:      cmd.root_step = 1'b1;
      wirms_pkg::ST_FINISH:    cmd.out_load  = !status.out_full || out_tready;
      default:                 cmd = '0;
    endcase
  end

  // A result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!status.out_full || out_tready))
    else $error("result loaded over a waiting beat");

  // Closing a window starts the divider
  a_close_div: assert property (@(posedge clk) disable iff (rst)
    (accept && status.close) |=> (state == wirms_pkg::ST_DIV))
    else $error("window close did not start the divide");

  // Divide runs its full count before the root starts
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == wirms_pkg::ST_DIV && step != '0) |=> (state == wirms_pkg::ST_DIV))
    else $error("divide cut short");

endmodule

// ===== rtl/core/windowed_integer_rms.sv =====
// Top level of the windowed integer RMS block.
// Squares each 16-bit unsigned sample into a 40-bit sum and, after window_length samples
// (zero counts as one), gives floor(sqrt(floor(sum / window_length))) as one output beat,
// then starts a new window. A sample that does not close a window leaves input ready for the
// next one. A sample that closes a window holds off input while the bit-serial divider runs,
// the root unit is loaded, the bit-serial square root runs over the full 40-bit mean and the
// result is handed to the output register, and for as long as the output register is still
// full. Writing window_length leaves the running sum and count alone; the new length applies
// from the next sample.
module windowed_integer_rms (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,       // window_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // [15:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata     // [15:0] rms_value
);

  wirms_pkg::dp_cmd_t    cmd;
  wirms_pkg::dp_status_t status;

  wirms_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (s_axis_tvalid),
    .in_tready  (s_axis_tready),
    .out_tready (m_axis_tready),
    .status     (status),
    .cmd        (cmd)
  );

  wirms_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .sample     (s_axis_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tready (m_axis_tready),
    .out_tvalid (m_axis_tvalid),
    .out_data   (m_axis_tdata)
  );

endmodule
